// File: design/sha1_message_digest_top_macros.svh
// ----------------------------------------------------------------------------
// SHA-1 message digest assertion macros
// Shared property wrappers on aclk; SHA1_MD_ASSERT is off in active-low reset.
// ----------------------------------------------------------------------------
`ifndef SHA1_MESSAGE_DIGEST_TOP_MACROS_SVH
`define SHA1_MESSAGE_DIGEST_TOP_MACROS_SVH

// Check a property outside reset.
`define SHA1_MD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Check a property on every edge, reset included.
`define SHA1_MD_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// File: design/sha1_md_pkg.sv
// ----------------------------------------------------------------------------
// SHA-1 message digest package
// Item types, block and hash array types, round constants and initial hash.
// ----------------------------------------------------------------------------
package sha1_md_pkg;

    typedef struct packed {
        logic [31:0] data_word;
        logic [2:0]  valid_bytes;
        logic        last_item;
    } in_item_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } out_item_t;

    typedef logic [15:0][31:0] block_arr_t;
    typedef logic [4:0][31:0]  hash_arr_t;

    typedef struct packed {
        logic start;      // load block and chain value, run 80 rounds
        logic init;       // return chain value to the initial hash
    } core_cmd_t;

    typedef struct packed {
        logic done;       // chain value updated this cycle
    } core_sts_t;

    localparam logic [31:0] K0 = 32'h5A827999;
    localparam logic [31:0] K1 = 32'h6ED9EBA1;
    localparam logic [31:0] K2 = 32'h8F1BBCDC;
    localparam logic [31:0] K3 = 32'hCA62C1D6;

    // Entry 0 is the most significant digest word.
    localparam hash_arr_t HASH_INIT = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                                       32'hEFCDAB89, 32'h67452301};

    localparam logic [7:0] PAD_BYTE  = 8'h80;
    localparam logic [6:0] LAST_ROUND = 7'd79;
    localparam logic [5:0] LEN_FILL  = 6'd56;
    localparam logic [5:0] FULL_FILL = 6'd63;
    localparam logic [2:0] LAST_IDX  = 3'd4;

endpackage

// File: design/sha1_message_digest_top.sv
// ----------------------------------------------------------------------------
// SHA-1 message digest engine
// Byte-packing sequencer around an iterative one-round-per-cycle core.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_valid/s_ready/s_data carries message words, first byte in
//   bits 31..24, with a count of valid leading bytes and a last-item flag.
//   Output channel m_valid/m_ready/m_data carries the five digest words,
//   index 0 first, with last_word set on index 4.
//   The sequencer writes the valid bytes of each accepted word one byte per
//   cycle into the 16-word block buffer, pausing while a block compresses.
//   Each full block is then loaded into the core, run through 80 rounds in
//   the shared round adder and folded into the chain value.
//   A last item adds padding one byte per cycle, pausing when a block fills;
//   the length write and one or two compressions precede the first digest word.
//   s_ready is low from acceptance until the item is fully processed and
//   while digest words are pending. A stalled receiver holds the current
//   digest word steady; after the fifth word is taken the chain value, bit
//   count and fill return to their initial values.
//   Reset (aresetn low, synchronous) restores the initial hash values and
//   clears bit count and fill; the block buffer keeps its contents.
// ----------------------------------------------------------------------------
module sha1_message_digest_top (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  sha1_md_pkg::in_item_t  s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output sha1_md_pkg::out_item_t m_data
);

    sha1_md_pkg::core_cmd_t  cmd;
    sha1_md_pkg::core_sts_t  sts;
    sha1_md_pkg::hash_arr_t  hash;
    sha1_md_pkg::block_arr_t blk;

    sha1_md_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .cmd     (cmd),
        .sts     (sts),
        .hash    (hash),
        .blk     (blk)
    );

    sha1_md_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .blk     (blk),
        .sts     (sts),
        .hash    (hash)
    );

endmodule

// File: design/sha1_md_core.sv
// ----------------------------------------------------------------------------
// SHA-1 compression core
// One round per cycle through a shared round adder, message schedule in a
// 16-word shift line, chain value update in the cycle after round 79.
// ----------------------------------------------------------------------------
module sha1_md_core (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  sha1_md_pkg::core_cmd_t cmd,
    input  sha1_md_pkg::block_arr_t blk,
    output sha1_md_pkg::core_sts_t sts,
    output sha1_md_pkg::hash_arr_t hash
);

    logic                    busy_reg;
    logic                    fin_reg;
    logic [6:0]              rnd_reg;
    sha1_md_pkg::hash_arr_t  hash_reg;
    logic [31:0]             a_reg, b_reg, c_reg, d_reg, e_reg;
    sha1_md_pkg::block_arr_t sr_reg;

    logic [31:0] sched_mix;
    logic [31:0] x;
    logic [31:0] f;
    logic [31:0] k;
    logic [31:0] tmp;

    always_comb begin
        sched_mix = sr_reg[13] ^ sr_reg[8] ^ sr_reg[2] ^ sr_reg[0];
        x = (rnd_reg < 7'd16) ? sr_reg[0] : {sched_mix[30:0], sched_mix[31]};
        if (rnd_reg < 7'd20) begin
            f = d_reg ^ (b_reg & (c_reg ^ d_reg));
            k = sha1_md_pkg::K0;
        end else if (rnd_reg < 7'd40) begin
            f = b_reg ^ c_reg ^ d_reg;
            k = sha1_md_pkg::K1;
        end else if (rnd_reg < 7'd60) begin
            f = (b_reg & c_reg) | (d_reg & (b_reg ^ c_reg));
            k = sha1_md_pkg::K2;
        end else begin
            f = b_reg ^ c_reg ^ d_reg;
            k = sha1_md_pkg::K3;
        end
        tmp = {a_reg[26:0], a_reg[31:27]} + f + e_reg + k + x;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            rnd_reg  <= 7'd0;
            hash_reg <= sha1_md_pkg::HASH_INIT;
        end else begin
            if (cmd.start) begin
                busy_reg <= 1'b1;
                rnd_reg  <= 7'd0;
            end else if (busy_reg) begin
                rnd_reg <= rnd_reg + 7'd1;
                if (rnd_reg == sha1_md_pkg::LAST_ROUND) begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
            end
            if (fin_reg) begin
                fin_reg     <= 1'b0;
                hash_reg[0] <= hash_reg[0] + a_reg;
                hash_reg[1] <= hash_reg[1] + b_reg;
                hash_reg[2] <= hash_reg[2] + c_reg;
                hash_reg[3] <= hash_reg[3] + d_reg;
                hash_reg[4] <= hash_reg[4] + e_reg;
            end else if (cmd.init) begin
                hash_reg <= sha1_md_pkg::HASH_INIT;
            end
        end
    end

    // Working variables and schedule carry no reset.
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            a_reg  <= hash_reg[0];
            b_reg  <= hash_reg[1];
            c_reg  <= hash_reg[2];
            d_reg  <= hash_reg[3];
            e_reg  <= hash_reg[4];
            sr_reg <= blk;
        end else if (busy_reg) begin
            a_reg  <= tmp;
            b_reg  <= a_reg;
            c_reg  <= {b_reg[1:0], b_reg[31:2]};
            d_reg  <= c_reg;
            e_reg  <= d_reg;
            sr_reg <= {x, sr_reg[15:1]};
        end
    end

    assign sts.done = fin_reg;
    assign hash     = hash_reg;

endmodule

// File: design/sha1_md_ctrl.sv
// ----------------------------------------------------------------------------
// SHA-1 message digest sequencer
// Packs message bytes into the block buffer one byte per cycle between
// compressions, pads, writes the length, starts the core, presents the digest.
// ----------------------------------------------------------------------------
module sha1_md_ctrl (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  sha1_md_pkg::in_item_t   s_data,
    output logic                    m_valid,
    input  logic                    m_ready,
    output sha1_md_pkg::out_item_t  m_data,
    output sha1_md_pkg::core_cmd_t  cmd,
    input  sha1_md_pkg::core_sts_t  sts,
    input  sha1_md_pkg::hash_arr_t  hash,
    output sha1_md_pkg::block_arr_t blk
);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_BYTE  = 7'b0000010,
        ST_PAD   = 7'b0000100,
        ST_ZERO  = 7'b0001000,
        ST_LEN   = 7'b0010000,
        ST_START = 7'b0100000,
        ST_HASH  = 7'b1000000
    } state_t;

    state_t      state_reg, state_next;
    state_t      ret_reg, ret_next;
    logic        out_reg, out_next;
    logic [5:0]  fill_reg, fill_next;
    logic [63:0] len_reg, len_next;
    logic [2:0]  oidx_reg, oidx_next;
    logic [31:0] word_reg, word_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic        last_reg, last_next;

    sha1_md_pkg::block_arr_t blk_reg;

    logic       wr_en;
    logic [7:0] wr_byte;
    logic       len_wr;
    logic [4:0] lane_lsb;

    assign s_ready  = (state_reg == ST_IDLE) && !out_reg;
    assign m_valid  = out_reg;
    assign lane_lsb = {~fill_reg[1:0], 3'b000};

    always_comb begin
        m_data.digest_word = hash[oidx_reg];
        m_data.word_index  = oidx_reg;
        m_data.last_word   = (oidx_reg == sha1_md_pkg::LAST_IDX);
    end

    always_comb begin
        state_next = state_reg;
        ret_next   = ret_reg;
        out_next   = out_reg;
        fill_next  = fill_reg;
        len_next   = len_reg;
        oidx_next  = oidx_reg;
        word_next  = word_reg;
        cnt_next   = cnt_reg;
        last_next  = last_reg;
        wr_en      = 1'b0;
        wr_byte    = 8'h00;
        len_wr     = 1'b0;
        cmd.start  = 1'b0;
        cmd.init   = 1'b0;

        if (out_reg) begin
            // Hold until each digest word is taken.
            if (m_ready) begin
                if (oidx_reg == sha1_md_pkg::LAST_IDX) begin
                    out_next  = 1'b0;
                    cmd.init  = 1'b1;
                    len_next  = 64'd0;
                    fill_next = 6'd0;
                end else begin
                    oidx_next = oidx_reg + 3'd1;
                end
            end
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        word_next  = s_data.data_word;
                        cnt_next   = s_data.valid_bytes[2] ? 3'd4 : s_data.valid_bytes;
                        last_next  = s_data.last_item;
                        state_next = ST_BYTE;
                    end
                end
                ST_BYTE: begin
                    if (cnt_reg == 3'd0) begin
                        state_next = last_reg ? ST_PAD : ST_IDLE;
                    end else begin
                        wr_en     = 1'b1;
                        wr_byte   = word_reg[31:24];
                        word_next = {word_reg[23:0], 8'h00};
                        cnt_next  = cnt_reg - 3'd1;
                        len_next  = len_reg + 64'd8;
                        fill_next = fill_reg + 6'd1;
                        if (fill_reg == sha1_md_pkg::FULL_FILL) begin
                            ret_next   = ST_BYTE;
                            state_next = ST_START;
                        end
                    end
                end
                ST_PAD: begin
                    wr_en     = 1'b1;
                    wr_byte   = sha1_md_pkg::PAD_BYTE;
                    fill_next = fill_reg + 6'd1;
                    if (fill_reg == sha1_md_pkg::FULL_FILL) begin
                        ret_next   = ST_ZERO;
                        state_next = ST_START;
                    end else begin
                        state_next = ST_ZERO;
                    end
                end
                ST_ZERO: begin
                    if (fill_reg == sha1_md_pkg::LEN_FILL) begin
                        state_next = ST_LEN;
                    end else begin
                        wr_en     = 1'b1;
                        fill_next = fill_reg + 6'd1;
                        if (fill_reg == sha1_md_pkg::FULL_FILL) begin
                            ret_next   = ST_ZERO;
                            state_next = ST_START;
                        end
                    end
                end
                ST_LEN: begin
                    len_wr     = 1'b1;
                    fill_next  = 6'd0;
                    ret_next   = ST_IDLE;
                    state_next = ST_START;
                end
                ST_START: begin
                    cmd.start  = 1'b1;
                    state_next = ST_HASH;
                end
                ST_HASH: begin
                    if (sts.done) begin
                        state_next = ret_reg;
                        // Final block of a message: present the digest.
                        if (ret_reg == ST_IDLE) begin
                            out_next  = 1'b1;
                            oidx_next = 3'd0;
                        end
                    end
                end
                default: begin
                    state_next = ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ret_reg   <= ST_IDLE;
            out_reg   <= 1'b0;
            fill_reg  <= 6'd0;
            len_reg   <= 64'd0;
            oidx_reg  <= 3'd0;
            cnt_reg   <= 3'd0;
            last_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            out_reg   <= out_next;
            fill_reg  <= fill_next;
            len_reg   <= len_next;
            oidx_reg  <= oidx_next;
            cnt_reg   <= cnt_next;
            last_reg  <= last_next;
        end
    end

    always_ff @(posedge aclk) begin
        word_reg <= word_next;
        if (wr_en) begin
            blk_reg[fill_reg[5:2]][lane_lsb +: 8] <= wr_byte;
        end
        if (len_wr) begin
            blk_reg[14] <= len_reg[63:32];
            blk_reg[15] <= len_reg[31:0];
        end
    end

    assign blk = blk_reg;

endmodule

// File: design/sha1_md_checker.sv
// ----------------------------------------------------------------------------
// SHA-1 message digest port checker
// Watches the top-level channels for ordering and hold rules of the block.
// ----------------------------------------------------------------------------
`include "sha1_message_digest_top_macros.svh"

module sha1_md_checker (
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_valid,
    input logic                   s_ready,
    input logic                   m_valid,
    input logic                   m_ready,
    input sha1_md_pkg::out_item_t m_data
);

    property p_out_hold;
        m_valid && !m_ready |=> m_valid && $stable(m_data);
    endproperty

    property p_out_order;
        m_valid && m_ready && !m_data.last_word |=>
            m_valid && (m_data.word_index == $past(m_data.word_index) + 3'd1);
    endproperty

    // Digest words must hold while the receiver stalls.
    `SHA1_MD_ASSERT(a_out_hold, p_out_hold, "digest item changed under stall")

    // Digest words come back to back in index order.
    `SHA1_MD_ASSERT(a_out_order, p_out_order, "digest index out of order")

    // No input is taken while digest words are pending.
    `SHA1_MD_ASSERT(a_no_in_during_out, m_valid |-> !s_ready, "input ready during digest output")

    // An accepted item makes the block busy in the next cycle.
    `SHA1_MD_ASSERT(a_busy_after_accept, s_valid && s_ready |=> !s_ready, "ready right after accept")

    // Reset leaves no digest pending.
    `SHA1_MD_ASSERT_ALWAYS(a_reset_quiet, !aresetn |=> !m_valid, "output valid after reset")

endmodule

bind sha1_message_digest_top sha1_md_checker u_sha1_md_checker (.*);

// File: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// SHA-1 message digest testbench
// Drives message words through valid/ready with bursty timing, predicts the
// five digest words of each message with a local SHA-1 model, and checks the
// result stream in order while the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module tb;

    localparam int CYCLE_LIMIT = 300000;
    localparam int TAIL_CYCLES = 400;
    localparam int RAND_ITEMS  = 120;

    typedef struct {
        sha1_md_pkg::in_item_t item;
        bit                    wait_idle;   // hold this item back until all digests are in
    } pend_word_t;

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   s_valid;
    logic                   s_ready;
    sha1_md_pkg::in_item_t  s_data;
    logic                   m_valid;
    logic                   m_ready;
    sha1_md_pkg::out_item_t m_data;

    pend_word_t             word_q[$];
    sha1_md_pkg::out_item_t digest_q[$];

    // Local copy of the hashing state.
    sha1_md_pkg::hash_arr_t  chain_val;
    sha1_md_pkg::block_arr_t blk_buf;
    logic [63:0]             bit_cnt;
    int unsigned             fill_cnt;

    int fail_cnt = 0;
    int got_cnt  = 0;
    int cyc_cnt  = 0;
    int burst_left;
    int gap_left;
    int hold_cnt;
    bit hold_done;
    int ph_left;
    int ready_pct;

    sha1_message_digest_top u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic void sha_compress();
        logic [31:0] w [16];
        logic [31:0] a, b, c, d, e, f, k, x, sum;
        for (int j = 0; j < 16; j++) begin
            w[j] = blk_buf[j];
        end
        a = chain_val[0];
        b = chain_val[1];
        c = chain_val[2];
        d = chain_val[3];
        e = chain_val[4];
        for (int t = 0; t < 80; t++) begin
            if (t < 16) begin
                x = w[t];
            end else begin
                x = w[t % 16] ^ w[(t - 14) % 16] ^ w[(t - 8) % 16] ^ w[(t - 3) % 16];
                x = {x[30:0], x[31]};
                w[t % 16] = x;
            end
            if (t < 20) begin
                f = d ^ (b & (c ^ d));
                k = sha1_md_pkg::K0;
            end else if (t < 40) begin
                f = b ^ c ^ d;
                k = sha1_md_pkg::K1;
            end else if (t < 60) begin
                f = (b & c) | (d & (b ^ c));
                k = sha1_md_pkg::K2;
            end else begin
                f = b ^ c ^ d;
                k = sha1_md_pkg::K3;
            end
            sum = {a[26:0], a[31:27]} + f + e + k + x;
            e = d;
            d = c;
            c = {b[1:0], b[31:2]};
            b = a;
            a = sum;
        end
        chain_val[0] = chain_val[0] + a;
        chain_val[1] = chain_val[1] + b;
        chain_val[2] = chain_val[2] + c;
        chain_val[3] = chain_val[3] + d;
        chain_val[4] = chain_val[4] + e;
    endfunction

    // Place one byte in the block and hash the block once it is full.
    function automatic void load_byte(logic [7:0] v);
        int idx;
        int sh;
        idx = fill_cnt / 4;
        sh = (3 - fill_cnt % 4) * 8;
        blk_buf[idx][sh +: 8] = v;
        fill_cnt++;
        if (fill_cnt >= 64) begin
            sha_compress();
            fill_cnt = 0;
        end
    endfunction

    function automatic void predict_digest(sha1_md_pkg::in_item_t it);
        int unsigned n;
        sha1_md_pkg::out_item_t r;
        n = (it.valid_bytes > 3'd4) ? 4 : it.valid_bytes;
        for (int i = 0; i < n; i++) begin
            load_byte(it.data_word[31 - 8 * i -: 8]);
            bit_cnt = bit_cnt + 64'd8;
        end
        if (!it.last_item) begin
            return;
        end
        load_byte(sha1_md_pkg::PAD_BYTE);
        if (fill_cnt > sha1_md_pkg::LEN_FILL) begin
            while (fill_cnt != 0) begin
                load_byte(8'h00);
            end
        end
        while (fill_cnt < sha1_md_pkg::LEN_FILL) begin
            load_byte(8'h00);
        end
        blk_buf[14] = bit_cnt[63:32];
        blk_buf[15] = bit_cnt[31:0];
        sha_compress();
        for (int i = 0; i < 5; i++) begin
            r.digest_word = chain_val[i];
            r.word_index  = i[2:0];
            r.last_word   = (i[2:0] == sha1_md_pkg::LAST_IDX);
            digest_q.push_back(r);
        end
        chain_val = sha1_md_pkg::HASH_INIT;
        bit_cnt   = '0;
        fill_cnt  = 0;
    endfunction

    task automatic add_word(logic [31:0] data, int vb, bit lst, bit wait_idle);
        pend_word_t p;
        p.item.data_word   = data;
        p.item.valid_bytes = vb[2:0];
        p.item.last_item   = lst;
        p.wait_idle        = wait_idle;
        word_q.push_back(p);
    endtask

    // Sender: bursts of items separated by random gaps.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid    <= 1'b0;
            burst_left <= $urandom_range(1, 12);
            gap_left   <= 0;
        end else begin
            if (s_valid && s_ready) begin
                predict_digest(s_data);
            end
            if (!s_valid || s_ready) begin
                if (gap_left != 0) begin
                    gap_left <= gap_left - 1;
                    s_valid  <= 1'b0;
                end else if (word_q.size() != 0 &&
                             !(word_q[0].wait_idle && digest_q.size() != 0)) begin
                    s_data  <= word_q[0].item;
                    s_valid <= 1'b1;
                    word_q.pop_front();
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 12);
                        gap_left   <= ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 15);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: stall rate changes by phase, plus one long hold-off.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready   <= 1'b0;
            hold_cnt  <= 0;
            hold_done <= 1'b0;
            ph_left   <= 0;
            ready_pct <= 100;
        end else if (hold_cnt != 0) begin
            hold_cnt <= hold_cnt - 1;
            m_ready  <= 1'b0;
        end else if (!hold_done && got_cnt >= 40 && m_valid && word_q.size() != 0 &&
                     !word_q[0].wait_idle) begin
            hold_cnt  <= 400;
            hold_done <= 1'b1;
            m_ready   <= 1'b0;
        end else begin
            if (ph_left == 0) begin
                ph_left <= $urandom_range(20, 80);
                case ($urandom_range(0, 2))
                    0: begin
                        ready_pct <= 100;
                    end
                    1: begin
                        ready_pct <= 75;
                    end
                    default: begin
                        ready_pct <= 35;
                    end
                endcase
            end else begin
                ph_left <= ph_left - 1;
            end
            m_ready <= ($urandom_range(0, 99) < ready_pct);
        end
    end

    // Compare each digest word against the oldest prediction.
    always @(posedge aclk) begin
        sha1_md_pkg::out_item_t exp_w;
        if (aresetn && m_valid && m_ready) begin
            got_cnt <= got_cnt + 1;
            if (digest_q.size() == 0) begin
                $display("%0t: unexpected digest word %h idx %0d", $time,
                         m_data.digest_word, m_data.word_index);
                fail_cnt++;
            end else begin
                exp_w = digest_q.pop_front();
                if (m_data.digest_word !== exp_w.digest_word) begin
                    $display("%0t: digest_word expected %h got %h", $time,
                             exp_w.digest_word, m_data.digest_word);
                    fail_cnt++;
                end
                if (m_data.word_index !== exp_w.word_index) begin
                    $display("%0t: word_index expected %0d got %0d", $time,
                             exp_w.word_index, m_data.word_index);
                    fail_cnt++;
                end
                if (m_data.last_word !== exp_w.last_word) begin
                    $display("%0t: last_word expected %b got %b", $time,
                             exp_w.last_word, m_data.last_word);
                    fail_cnt++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cyc_cnt <= cyc_cnt + 1;
        if (cyc_cnt == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        int n_items;
        int msg;
        int len;
        int vb;
        int sel;
        bit lst;
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        m_ready   = 1'b0;
        chain_val = sha1_md_pkg::HASH_INIT;
        blk_buf   = '0;
        bit_cnt   = '0;
        fill_cnt  = 0;

        // Empty message, "abc", and a full all-ones last word.
        add_word(32'h0000_0000, 0, 1'b1, 1'b0);
        add_word(32'h6162_6300, 3, 1'b1, 1'b0);
        add_word(32'hFFFF_FFFF, 4, 1'b1, 1'b0);
        // Counts above four act as four; empty last word ends the message.
        add_word(32'hFFFF_FFFF, 5, 1'b0, 1'b0);
        add_word(32'h0123_4567, 6, 1'b0, 1'b0);
        add_word(32'h89AB_CDEF, 7, 1'b0, 1'b0);
        add_word(32'hFFFF_FFFF, 0, 1'b1, 1'b0);
        // 56 bytes: padding spills into a second block.
        add_word(32'h0000_0000, 4, 1'b0, 1'b1);
        for (int i = 0; i < 13; i++) begin
            add_word($urandom, 4, 1'b0, 1'b0);
        end
        add_word($urandom, 0, 1'b1, 1'b0);
        // Short words ahead of the last one pack at byte granularity.
        add_word(32'hA5FF_FFFF, 1, 1'b0, 1'b1);
        add_word(32'h5A3C_0000, 2, 1'b0, 1'b0);
        add_word(32'hC3E1_7FFF, 3, 1'b1, 1'b0);

        n_items = 0;
        msg = 0;
        while (n_items < RAND_ITEMS) begin
            sel = $urandom_range(0, 9);
            if (sel < 6) begin
                len = $urandom_range(1, 18);
            end else if (sel < 8) begin
                len = $urandom_range(19, 40);
            end else begin
                len = $urandom_range(1, 3);
            end
            for (int j = 0; j < len; j++) begin
                lst = (j == len - 1);
                if (lst) begin
                    vb = $urandom_range(0, 7);
                end else begin
                    vb = ($urandom_range(0, 19) < 17) ? 4 : $urandom_range(0, 7);
                end
                add_word($urandom, vb, lst, (j == 0) && (msg % 5 == 4));
            end
            n_items += len;
            msg++;
        end

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        while (word_q.size() != 0 || s_valid) begin
            @(posedge aclk);
        end
        while (digest_q.size() != 0) begin
            @(posedge aclk);
        end
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_cnt == 0 && digest_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
